@@ hdl/fpss_pkg.sv @@
package fpss_pkg;

  // Default sizes, overridable on the top level
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_WIDTH_DEF     = 24;
  localparam int COEF_FRAC_BITS_DEF = 20;

  // Internal state word, fixed by the filter's number format
  localparam int STATE_BITS = 48;

  // Number of cells in the state chain (second-order section)
  localparam int NUM_STATES = 2;

  // Configuration register file
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FEED   = 3'd0,
    REG_S1_IN  = 3'd1,
    REG_S2_IN  = 3'd2,
    REG_FB1    = 3'd3,
    REG_FB2    = 3'd4
  } reg_idx_e;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic step;   // a sample transfer happens this cycle
    logic clear;  // zero the state
  } cell_ctl_t;

endpackage

@@ hdl/fpss_cell.sv @@
module fpss_cell import fpss_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cell_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] e_i,
  input  logic signed [STATE_BITS-1:0]   s1_i,      // head-of-chain state, old value
  input  logic signed [STATE_BITS-1:0]   chain_i,   // state of the next cell down
  input  logic signed [COEF_WIDTH-1:0]   coef_in_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_fb_i,
  output logic signed [STATE_BITS-1:0]   state_o
);

  localparam int HW   = STATE_BITS / 2;
  localparam int HIW  = STATE_BITS - HW;
  localparam int LPW  = HW + 1 + COEF_WIDTH;
  localparam int HPW  = HIW + COEF_WIDTH;
  localparam int PW   = STATE_BITS + COEF_WIDTH;
  localparam int RW   = PW - COEF_FRAC_BITS;
  localparam int XW   = (RW > STATE_BITS) ? RW : STATE_BITS;
  localparam int PEW  = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int SUMW = ((STATE_BITS + 1 > PEW) ? STATE_BITS + 1 : PEW) + 2;

  localparam logic signed [PW-1:0]   HALF   = PW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [XW-1:0]   X_MAX  = XW'({1'b0, {(STATE_BITS-1){1'b1}}});
  localparam logic signed [XW-1:0]   X_MIN  = -X_MAX - XW'(1);
  localparam logic signed [SUMW-1:0] SU_MAX = SUMW'({1'b0, {(STATE_BITS-1){1'b1}}});
  localparam logic signed [SUMW-1:0] SU_MIN = -SU_MAX - SUMW'(1);

  logic signed [STATE_BITS-1:0] state_q, state_d;
  logic signed [LPW-1:0]        pp_lo;
  logic signed [HPW-1:0]        pp_hi;
  logic signed [PW-1:0]         prod, prod_r;
  logic signed [XW-1:0]         fb_full;
  logic signed [STATE_BITS-1:0] fb_sat;
  logic signed [PEW-1:0]        in_prod;
  logic signed [SUMW-1:0]       sum;
  logic signed [STATE_BITS-1:0] sum_sat;

  // Feedback product d*s1 from two half-word partial products
  assign pp_lo  = LPW'($signed({1'b0, s1_i[HW-1:0]})) * LPW'(coef_fb_i);
  assign pp_hi  = HPW'($signed(s1_i[STATE_BITS-1:HW])) * HPW'(coef_fb_i);
  assign prod   = (PW'(pp_hi) <<< HW) + PW'(pp_lo);
  assign prod_r = prod + HALF;
  assign fb_full = XW'($signed(prod_r[PW-1:COEF_FRAC_BITS]));

  always_comb begin
    if (fb_full > X_MAX) begin
      fb_sat = STATE_BITS'(X_MAX);
    end else if (fb_full < X_MIN) begin
      fb_sat = STATE_BITS'(X_MIN);
    end else begin
      fb_sat = fb_full[STATE_BITS-1:0];
    end
  end

  assign in_prod = PEW'(coef_in_i) * PEW'(e_i);
  assign sum     = SUMW'(chain_i) - SUMW'(fb_sat) + SUMW'(in_prod);

  always_comb begin
    if (sum > SU_MAX) begin
      sum_sat = STATE_BITS'(SU_MAX);
    end else if (sum < SU_MIN) begin
      sum_sat = STATE_BITS'(SU_MIN);
    end else begin
      sum_sat = sum[STATE_BITS-1:0];
    end
  end

  always_comb begin
    priority if (ctl_i.clear) begin
      state_d = '0;
    end else if (ctl_i.step) begin
      state_d = sum_sat;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

@@ hdl/fpss_out_stage.sv @@
module fpss_out_stage import fpss_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic signed [SAMPLE_WIDTH-1:0] e_i,
  input  logic signed [STATE_BITS-1:0]   s1_i,
  input  logic signed [COEF_WIDTH-1:0]   coef_i,
  input  logic                           ready_i,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] drive_o,
  output logic                           sat_o
);

  localparam int PEW = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int UW  = ((STATE_BITS > PEW) ? STATE_BITS : PEW) + 1;
  localparam int RW  = UW + 1 - COEF_FRAC_BITS;
  localparam int YW  = (RW > SAMPLE_WIDTH) ? RW : SAMPLE_WIDTH;

  localparam logic signed [UW:0]   HALF  = (UW + 1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [YW-1:0] Y_MAX = YW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

  logic signed [PEW-1:0]          feed;
  logic signed [UW:0]             u_r;
  logic signed [YW-1:0]           y_full;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                           clip;

  logic                           valid_q, valid_d;
  logic signed [SAMPLE_WIDTH-1:0] drive_q;
  logic                           sat_q;

  assign feed   = PEW'(coef_i) * PEW'(e_i);
  assign u_r    = (UW + 1)'(s1_i) + (UW + 1)'(feed) + HALF;
  assign y_full = YW'($signed(u_r[UW:COEF_FRAC_BITS]));

  always_comb begin
    clip = 1'b1;
    if (y_full > Y_MAX) begin
      y_sat = SAMPLE_WIDTH'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_sat = SAMPLE_WIDTH'(Y_MIN);
    end else begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
      clip  = 1'b0;
    end
  end

  always_comb begin
    priority if (step_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads only on a sample transfer
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      drive_q <= y_sat;
      sat_q   <= clip;
    end
  end

  assign valid_o = valid_q;
  assign drive_o = drive_q;
  assign sat_o   = sat_q;

endmodule

@@ hdl/filtered_pid_state_space_step.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: error_sample
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: drive_value, tuser: saturated
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One sample per clock while no result is held; the result sits in the output register
// in the next cycle. The figure is set by the state recurrence: each cell closes d*s1
// (two half-word partial products), rounding, saturation and the state add combinationally.
// Reset clears coefficients, both states and the output valid; cfg_ready_o is always high.
// A held result (m_axis_tready low) drops s_axis_tready and freezes the states.
// A write to any listed register zeroes both states; other indexes are ignored.
module filtered_pid_state_space_step import fpss_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int DW            = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DW-1:0]         s_axis_tdata,   // [SAMPLE_WIDTH-1:0] error_sample, rest zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DW-1:0]         m_axis_tdata,   // [SAMPLE_WIDTH-1:0] drive_value, rest zero
  output logic [0:0]            m_axis_tuser,   // [0] saturated
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEF_WIDTH-1:0] cfg_data_i
);

  logic signed [COEF_WIDTH-1:0]   coef_q [NUM_REGS];
  logic                           cfg_hit;
  logic                           step;
  cell_ctl_t                      ctl;
  logic signed [SAMPLE_WIDTH-1:0] e;
  logic signed [STATE_BITS-1:0]   state_w [NUM_STATES+1];
  logic signed [COEF_WIDTH-1:0]   coef_in_w [NUM_STATES];
  logic signed [COEF_WIDTH-1:0]   coef_fb_w [NUM_STATES];
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] drive;
  logic                           sat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(cfg_index_i))
      REG_FEED, REG_S1_IN, REG_S2_IN, REG_FB1, REG_FB2: cfg_hit = cfg_valid_i;
      default:                                          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_hit) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign ctl.step      = step;
  assign ctl.clear     = cfg_hit;
  assign e             = s_axis_tdata[SAMPLE_WIDTH-1:0];

  assign coef_in_w[0] = coef_q[REG_S1_IN];
  assign coef_in_w[1] = coef_q[REG_S2_IN];
  assign coef_fb_w[0] = coef_q[REG_FB1];
  assign coef_fb_w[1] = coef_q[REG_FB2];

  // End of the chain feeds zero into the last cell
  assign state_w[NUM_STATES] = '0;

  for (genvar k = 0; k < NUM_STATES; k++) begin : g_cell
    fpss_cell #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_WIDTH    (COEF_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .e_i      (e),
      .s1_i     (state_w[0]),
      .chain_i  (state_w[k+1]),
      .coef_in_i(coef_in_w[k]),
      .coef_fb_i(coef_fb_w[k]),
      .state_o  (state_w[k])
    );
  end

  fpss_out_stage #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_WIDTH    (COEF_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .e_i    (e),
    .s1_i   (state_w[0]),
    .coef_i (coef_q[REG_FEED]),
    .ready_i(m_axis_tready),
    .valid_o(out_valid),
    .drive_o(drive),
    .sat_o  (sat)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DW'($unsigned(drive));
  assign m_axis_tuser  = sat;

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (state_w[0] == '0) && (state_w[1] == '0))
    else $error("states not cleared after register write");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("sample transfer produced no result");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !cfg_hit) |=>
      ($stable(state_w[0]) && $stable(state_w[1])))
    else $error("state advanced while output stalled");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      ((drive == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) ||
       (drive == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})))
    else $error("saturated flag without limit value");

endmodule
